// ===== rtl/skt_pkg.sv =====
// Package for the sorted key table: field structs, status codes, controller
// states and the command and status groups between controller and datapath.
// Used by skt_ctrl, skt_datapath and sorted_key_table. Depends on nothing.
`default_nettype none

package skt_pkg;

  // Default configuration of the table.
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_KEY_WIDTH   = 32;

  // Fixed field widths of the command and result words.
  localparam int KEY_FIELD_W = 32;
  localparam int MAX_KEY_W   = 64;
  localparam int TAG_W       = 16;
  localparam int LINE_W      = 20;
  localparam int SLOT_W      = 10;
  localparam int CNT_W       = 11;

  // Operation requested by a command word.
  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_e;

  // Outcome reported in a result word.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_SHIFT,
    S_DRAIN,
    S_PLACE,
    S_FINISH
  } state_e;

  // Command word.
  typedef struct packed {
    action_e                  action;
    logic [KEY_FIELD_W-1:0]   key;
    logic [TAG_W-1:0]         source_tag;
    logic [LINE_W-1:0]        line_number;
  } req_t;

  // Result word.
  typedef struct packed {
    status_e                  status;
    logic [SLOT_W-1:0]        slot;
    logic [CNT_W-1:0]         entry_count;
    logic [CNT_W-1:0]         high_water;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;      // latch a new command word
    logic    rd_mid;      // read the entry at the search midpoint
    logic    step;        // narrow the search range from the read entry
    logic    shift_init;  // load the shift pointer
    logic    shift_rd;    // read one entry to be moved
    logic    place;       // write the new entry at its sorted position
    logic    remove_done; // drop the entry count by one
    logic    load_res;    // capture the result word
    status_e res_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic lo_lt_hi;
    logic found;
    logic is_remove;
    logic needs_shift;
    logic shift_last;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_key_table.sv =====
// Top level of the sorted key table: joins the controller and the datapath.
// Depends on skt_pkg, skt_ctrl and skt_datapath.
`default_nettype none

// A command word is taken when start is high and busy is low. Its result word
// appears on result_o, marked by done_o, for exactly one cycle; the receiver
// must take it then. A command passes through an accept step, binary search probes
// (about log2(entries + 1) of them), each a midpoint read and a compare, the move of
// each entry that must shift, and write-back and result capture; an insert into a
// full table answers straight from the accept. The entry memory makes one registered
// read and one write per cycle. Busy drops as the result is captured, so the next
// command may be taken in the cycle its predecessor's result is shown.
module sorted_key_table #(
  parameter int TABLE_DEPTH = skt_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = skt_pkg::DEF_KEY_WIDTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire skt_pkg::req_t req_i,
  output skt_pkg::res_t   result_o,
  output logic            done_o
);

  skt_pkg::cmd_t  cmd;
  skt_pkg::stat_t stat;

  // Sequencer.
  skt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (req_i.action),
    .stat_i   (stat),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  // Storage and arithmetic.
  skt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .result_o (result_o),
    .done_o   (done_o)
  );

  // An accepted command either keeps the block busy or answers at once.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted command neither started work nor answered");

  // A command that changes nothing reports slot zero.
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != skt_pkg::ST_DONE) |-> (result_o.slot == '0))
    else $error("nonzero slot on an unsuccessful command");

  // A full table has reached its high-water mark.
  a_full_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == skt_pkg::ST_FULL)
      |-> (result_o.entry_count == result_o.high_water))
    else $error("table full reported below the high-water mark");

  // The memory never moves an entry and places a new one in the same cycle.
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.place |-> $past(!cmd.shift_rd))
    else $error("new entry placed while a moved entry is still pending");

endmodule

`default_nettype wire

// ===== rtl/skt_ctrl.sv =====
// Controller of the sorted key table: sequences the binary search, the entry
// shift and the result capture. Depends on skt_pkg; drives skt_datapath.
`default_nettype none

module skt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire skt_pkg::action_e action_i,
  input  wire skt_pkg::stat_t   stat_i,
  output logic               busy,
  output skt_pkg::cmd_t      cmd_o
);

  skt_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.res_status  = skt_pkg::ST_DONE;
    busy              = 1'b1;
    unique case (state_q)
      skt_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.accept = 1'b1;
          if (action_i == skt_pkg::ACT_INSERT && stat_i.full) begin
            // A full table answers at once and changes nothing.
            cmd_o.load_res   = 1'b1;
            cmd_o.res_status = skt_pkg::ST_FULL;
          end else begin
            state_d = skt_pkg::S_PROBE;
          end
        end
      end
      skt_pkg::S_PROBE: begin
        if (stat_i.lo_lt_hi) begin
          cmd_o.rd_mid = 1'b1;
          state_d      = skt_pkg::S_CMP;
        end else if (!stat_i.is_remove) begin
          if (stat_i.found) begin
            cmd_o.load_res   = 1'b1;
            cmd_o.res_status = skt_pkg::ST_PRESENT;
            state_d          = skt_pkg::S_IDLE;
          end else if (stat_i.needs_shift) begin
            cmd_o.shift_init = 1'b1;
            state_d          = skt_pkg::S_SHIFT;
          end else begin
            state_d = skt_pkg::S_PLACE;
          end
        end else begin
          if (!stat_i.found) begin
            cmd_o.load_res   = 1'b1;
            cmd_o.res_status = skt_pkg::ST_NOT_FOUND;
            state_d          = skt_pkg::S_IDLE;
          end else if (stat_i.needs_shift) begin
            cmd_o.shift_init = 1'b1;
            state_d          = skt_pkg::S_SHIFT;
          end else begin
            state_d = skt_pkg::S_FINISH;
          end
        end
      end
      skt_pkg::S_CMP: begin
        cmd_o.step = 1'b1;
        state_d    = skt_pkg::S_PROBE;
      end
      skt_pkg::S_SHIFT: begin
        cmd_o.shift_rd = 1'b1;
        if (stat_i.shift_last) begin
          state_d = skt_pkg::S_DRAIN;
        end
      end
      skt_pkg::S_DRAIN: begin
        // The last moved entry is written back in this cycle.
        state_d = stat_i.is_remove ? skt_pkg::S_FINISH : skt_pkg::S_PLACE;
      end
      skt_pkg::S_PLACE: begin
        cmd_o.place    = 1'b1;
        cmd_o.load_res = 1'b1;
        state_d        = skt_pkg::S_IDLE;
      end
      skt_pkg::S_FINISH: begin
        cmd_o.remove_done = 1'b1;
        cmd_o.load_res    = 1'b1;
        state_d           = skt_pkg::S_IDLE;
      end
      default: begin
        state_d = skt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/skt_datapath.sv =====
// Datapath of the sorted key table: entry memory, search range, shift pointer,
// entry count, high-water mark and result register. Depends on skt_pkg.
`default_nettype none

module skt_datapath #(
  parameter int TABLE_DEPTH = skt_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = skt_pkg::DEF_KEY_WIDTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire skt_pkg::req_t req_i,
  input  wire skt_pkg::cmd_t cmd_i,
  output skt_pkg::stat_t   stat_o,
  output skt_pkg::res_t    result_o,
  output logic             done_o
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = KEY_WIDTH + skt_pkg::TAG_W + skt_pkg::LINE_W;

  // Entry memory: key in the top bits, then tag, then line number.
  logic [EW-1:0] mem [TABLE_DEPTH];

  // Latched command word.
  skt_pkg::action_e                action_q;
  logic [KEY_WIDTH-1:0]            key_q;
  logic [skt_pkg::TAG_W-1:0]       tag_q;
  logic [skt_pkg::LINE_W-1:0]      line_q;

  // Search and shift state.
  logic [CW-1:0] lo_q, hi_q, mid;
  logic          found_q;
  logic [IW-1:0] ptr_q;
  logic [IW-1:0] rd_addr, rd_addr_q, wr_addr;
  logic [EW-1:0] rd_q;
  logic          pend_q;
  logic [KEY_WIDTH-1:0] rd_key;

  // Occupancy.
  logic [CW-1:0] count_q, count_d, peak_q, peak_d;

  // Result register.
  skt_pkg::res_t res_q;
  logic          done_q;

  logic [skt_pkg::MAX_KEY_W-1:0] key_ext;

  assign key_ext = skt_pkg::MAX_KEY_W'(req_i.key);
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign rd_addr = cmd_i.rd_mid ? mid[IW-1:0] : ptr_q;
  assign rd_key  = rd_q[EW-1 -: KEY_WIDTH];
  assign wr_addr = (action_q == skt_pkg::ACT_REMOVE) ? rd_addr_q - IW'(1)
                                                     : rd_addr_q + IW'(1);

  // Status toward the controller.
  always_comb begin
    stat_o.full      = (count_q == CW'(TABLE_DEPTH));
    stat_o.lo_lt_hi  = (lo_q < hi_q);
    stat_o.found     = found_q;
    stat_o.is_remove = (action_q == skt_pkg::ACT_REMOVE);
    if (action_q == skt_pkg::ACT_REMOVE) begin
      stat_o.needs_shift = ({1'b0, lo_q} + (CW + 1)'(1)) < {1'b0, count_q};
      stat_o.shift_last  = (CW'(ptr_q) + CW'(1)) == count_q;
    end else begin
      stat_o.needs_shift = (lo_q != count_q);
      stat_o.shift_last  = (ptr_q == lo_q[IW-1:0]);
    end
  end

  // Command word capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= req_i.action;
      key_q    <= key_ext[KEY_WIDTH-1:0];
      tag_q    <= req_i.source_tag;
      line_q   <= req_i.line_number;
    end
  end

  // Binary search range and shift pointer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      lo_q    <= '0;
      hi_q    <= count_q;
      found_q <= 1'b0;
    end else if (cmd_i.step) begin
      if (rd_key < key_q) begin
        lo_q <= mid + CW'(1);
      end else begin
        hi_q <= mid;
      end
      if (rd_key == key_q) begin
        found_q <= 1'b1;
      end
    end
    if (cmd_i.shift_init) begin
      if (action_q == skt_pkg::ACT_REMOVE) begin
        ptr_q <= IW'(lo_q + CW'(1));
      end else begin
        ptr_q <= IW'(count_q - CW'(1));
      end
    end else if (cmd_i.shift_rd) begin
      if (action_q == skt_pkg::ACT_REMOVE) begin
        ptr_q <= ptr_q + IW'(1);
      end else begin
        ptr_q <= ptr_q - IW'(1);
      end
    end
  end

  // Memory: one registered read, one write per cycle. A moved entry is written
  // the cycle after it is read, one slot up on insert or down on remove.
  always_ff @(posedge clk_i) begin
    rd_q      <= mem[rd_addr];
    rd_addr_q <= rd_addr;
    if (pend_q) begin
      mem[wr_addr] <= rd_q;
    end else if (cmd_i.place) begin
      mem[lo_q[IW-1:0]] <= {key_q, tag_q, line_q};
    end
  end

  // Entry count and high-water mark.
  always_comb begin
    count_d = count_q;
    if (cmd_i.place) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.remove_done) begin
      count_d = count_q - CW'(1);
    end
    peak_d = (count_d > peak_q) ? count_d : peak_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      peak_q  <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      peak_q  <= peak_d;
      pend_q  <= cmd_i.shift_rd;
      done_q  <= cmd_i.load_res;
    end
  end

  // Result word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      res_q.status      <= cmd_i.res_status;
      res_q.slot        <= (cmd_i.res_status == skt_pkg::ST_DONE) ?
                           skt_pkg::SLOT_W'(lo_q) : '0;
      res_q.entry_count <= skt_pkg::CNT_W'(count_d);
      res_q.high_water  <= skt_pkg::CNT_W'(peak_d);
    end
  end

  assign result_o = res_q;
  assign done_o   = done_q;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for sorted_key_table. It covers insert and remove,
// the empty table, field extremes and random traffic over a small key pool.
// Depends on skt_pkg and the sorted_key_table RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = skt_pkg::DEF_TABLE_DEPTH;
  localparam int POOL_SIZE = 40;
  localparam int RANDOM_WORDS = 552;
  localparam int DRAIN_CYCLES = 1100;
  localparam int MAX_REPORTS = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  skt_pkg::req_t req_i = '0;
  skt_pkg::res_t result_o;
  logic done_o;

  // Words waiting to be sent and results still owed by the block.
  skt_pkg::req_t pending_cmds[$];
  skt_pkg::res_t expected_results[$];
  int unsigned idle_pct = 0;
  int unsigned mismatch_count = 0;

  // Shadow copy of the table contents.
  logic [skt_pkg::KEY_FIELD_W-1:0] tbl_key[DEPTH];
  logic [skt_pkg::TAG_W-1:0] tbl_tag[DEPTH];
  logic [skt_pkg::LINE_W-1:0] tbl_line[DEPTH];
  int tbl_count = 0;
  int tbl_peak = 0;

  logic [skt_pkg::KEY_FIELD_W-1:0] key_pool[POOL_SIZE];

  sorted_key_table dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .req_i(req_i),
    .result_o(result_o),
    .done_o(done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one command word to the shadow table and returns its result.
  function automatic skt_pkg::res_t table_apply(skt_pkg::req_t cmd);
    skt_pkg::res_t r;
    int lo;
    int hi;
    int mid;
    int pos;
    logic hit;
    r.status = skt_pkg::ST_DONE;
    r.slot = '0;
    if (cmd.action == skt_pkg::ACT_INSERT && tbl_count >= DEPTH) begin
      r.status = skt_pkg::ST_FULL;
    end else begin
      // Lower bound over the valid entries.
      lo = 0;
      hi = tbl_count;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (tbl_key[mid] < cmd.key) lo = mid + 1;
        else hi = mid;
      end
      pos = lo;
      hit = (pos < tbl_count) && (tbl_key[pos] == cmd.key);
      if (cmd.action == skt_pkg::ACT_INSERT) begin
        if (hit) begin
          r.status = skt_pkg::ST_PRESENT;
        end else begin
          for (int i = tbl_count; i > pos; i--) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_tag[i] = tbl_tag[i-1];
            tbl_line[i] = tbl_line[i-1];
          end
          tbl_key[pos] = cmd.key;
          tbl_tag[pos] = cmd.source_tag;
          tbl_line[pos] = cmd.line_number;
          tbl_count++;
          if (tbl_count > tbl_peak) tbl_peak = tbl_count;
          r.slot = pos[skt_pkg::SLOT_W-1:0];
        end
      end else if (!hit) begin
        r.status = skt_pkg::ST_NOT_FOUND;
      end else begin
        for (int i = pos; i < tbl_count - 1; i++) begin
          tbl_key[i] = tbl_key[i+1];
          tbl_tag[i] = tbl_tag[i+1];
          tbl_line[i] = tbl_line[i+1];
        end
        tbl_count--;
        tbl_key[tbl_count] = '0;
        tbl_tag[tbl_count] = '0;
        tbl_line[tbl_count] = '0;
        r.slot = pos[skt_pkg::SLOT_W-1:0];
      end
    end
    r.entry_count = tbl_count[skt_pkg::CNT_W-1:0];
    r.high_water = tbl_peak[skt_pkg::CNT_W-1:0];
    return r;
  endfunction

  task automatic push_cmd(skt_pkg::action_e act, logic [skt_pkg::KEY_FIELD_W-1:0] key,
                          logic [skt_pkg::TAG_W-1:0] tag,
                          logic [skt_pkg::LINE_W-1:0] line);
    skt_pkg::req_t w;
    w.action = act;
    w.key = key;
    w.source_tag = tag;
    w.line_number = line;
    pending_cmds.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Driver: holds start until the word is taken, then picks the next one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_results.push_back(table_apply(req_i));
      if (!start || !busy) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          req_i <= pending_cmds.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("ERROR: result with none expected: status=%0d slot=%0d count=%0d hw=%0d",
                   result_o.status, result_o.slot, result_o.entry_count,
                   result_o.high_water);
      end else begin
        skt_pkg::res_t exp_r;
        exp_r = expected_results.pop_front();
        if (result_o.status !== exp_r.status || result_o.slot !== exp_r.slot ||
            result_o.entry_count !== exp_r.entry_count ||
            result_o.high_water !== exp_r.high_water) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ERROR: expected status=%0d slot=%0d count=%0d hw=%0d, got %0d %0d %0d %0d",
                     exp_r.status, exp_r.slot, exp_r.entry_count, exp_r.high_water,
                     result_o.status, result_o.slot, result_o.entry_count,
                     result_o.high_water);
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned pcts[4];
    pcts = '{0, 62, 0, 17};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, field extremes, ends and middle of the order.
    push_cmd(skt_pkg::ACT_REMOVE, 32'h0, 16'h0, 20'h0);
    push_cmd(skt_pkg::ACT_INSERT, 32'h8000_0000, 16'hFFFF, 20'hF_FFFF);
    push_cmd(skt_pkg::ACT_INSERT, 32'h0, 16'h0, 20'h0);
    push_cmd(skt_pkg::ACT_INSERT, 32'hFFFF_FFFF, 16'hA5A5, 20'h5_A5A5);
    push_cmd(skt_pkg::ACT_INSERT, 32'h0, 16'h1234, 20'h1_2345);
    push_cmd(skt_pkg::ACT_INSERT, 32'h7FFF_FFFF, 16'h5A5A, 20'hA_5A5A);
    push_cmd(skt_pkg::ACT_INSERT, 32'h8000_0001, 16'h0001, 20'h8_0000);
    push_cmd(skt_pkg::ACT_INSERT, 32'hFFFF_FFFF, 16'h0, 20'h0);
    push_cmd(skt_pkg::ACT_REMOVE, 32'h0001_2345, 16'h0, 20'h0);
    push_cmd(skt_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 16'h0, 20'h0);
    push_cmd(skt_pkg::ACT_REMOVE, 32'h0, 16'hFFFF, 20'hF_FFFF);
    push_cmd(skt_pkg::ACT_REMOVE, 32'h8000_0000, 16'h0, 20'h0);
    push_cmd(skt_pkg::ACT_REMOVE, 32'h8000_0000, 16'h0, 20'h0);
    push_cmd(skt_pkg::ACT_INSERT, 32'h0, 16'hFFFF, 20'hF_FFFF);
    push_cmd(skt_pkg::ACT_REMOVE, 32'h7FFF_FFFF, 16'h0, 20'h0);
    push_cmd(skt_pkg::ACT_REMOVE, 32'h8000_0001, 16'h0, 20'h0);
    push_cmd(skt_pkg::ACT_REMOVE, 32'h0, 16'h0, 20'h0);
    push_cmd(skt_pkg::ACT_REMOVE, 32'h0, 16'h0, 20'h0);
    wait_drained();

    // Random traffic over a small key pool so hits and misses both occur.
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = pcts[ph];
      for (int n = 0; n < RANDOM_WORDS / 4; n++) begin
        if ($urandom_range(99) < 8)
          push_cmd(skt_pkg::action_e'($urandom_range(1)), $urandom,
                   skt_pkg::TAG_W'($urandom), skt_pkg::LINE_W'($urandom));
        else
          push_cmd($urandom_range(99) < 55 ? skt_pkg::ACT_INSERT : skt_pkg::ACT_REMOVE,
                   key_pool[$urandom_range(POOL_SIZE - 1)], skt_pkg::TAG_W'($urandom),
                   skt_pkg::LINE_W'($urandom));
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
